// ----- rtl/core/bsl_pkg.sv -----
// Package for the bounded sequential list: field widths, list capacity,
// operation and status codes, and the sequencer state type.
// Used by the channel interfaces, the top level and the entry RAM instance.
package bsl_pkg;

   localparam int CAPACITY = 8;

   localparam int OP_W     = 3;
   localparam int KEY_W    = 32;
   localparam int POS_W    = 4;
   localparam int STAT_W   = 2;
   localparam int FIDX_W   = 4;
   localparam int COUNT_W  = 4;

   // Entry address width and the width of a counter that can hold CAPACITY.
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [OP_W-1:0] OP_SEARCH = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_POS  = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

   localparam logic [FIDX_W-1:0] NONE_INDEX = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_FINISH
   } state_type;

endpackage

// ----- rtl/core/bsl_if.sv -----
// Request and response channel interfaces of the bounded sequential list.
// Depends on bsl_pkg for the payload widths.
interface bsl_req_if;
   logic                            valid;
   logic                            ready;
   logic [bsl_pkg::OP_W-1:0]        op;
   logic signed [bsl_pkg::KEY_W-1:0] key;
   logic [bsl_pkg::POS_W-1:0]       position;

   modport source (output valid, op, key, position, input ready);
   modport sink   (input valid, op, key, position, output ready);
endinterface

interface bsl_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [bsl_pkg::STAT_W-1:0]        status;
   logic signed [bsl_pkg::FIDX_W-1:0] found_index;
   logic [bsl_pkg::COUNT_W-1:0]       count;

   modport source (output valid, status, found_index, count, input ready);
   modport sink   (input valid, status, found_index, count, output ready);
endinterface

// ----- rtl/core/bsl_ram.sv -----
// Simple dual-port RAM holding the list entries: one write port and one
// read port with registered read data. Standalone, no package dependency.
module bsl_ram #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 32,
   parameter int AW    = 3
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/bounded_sequential_list.sv -----
// Bounded sequential list. One request at a time; a search or delete walks the
// entries through the single RAM read port, a read state and a compare state per
// entry visited, and an insert moves each later entry up with a read and a write
// state. Clear, append and rejected requests go straight to the finish state. The
// next request is taken in the cycle the response appears. Sync reset empties the
// list and drops any pending response; entries are not cleared.
module bounded_sequential_list (
   input  logic             clock,
   input  logic             reset,
   bsl_req_if.sink          req_ch,
   bsl_rsp_if.source        rsp_ch
);

   bsl_pkg::state_type               state_ff, state_in;
   logic [bsl_pkg::OP_W-1:0]         op_ff, op_in;
   logic [bsl_pkg::KEY_W-1:0]        key_ff, key_in;
   logic [bsl_pkg::POS_W-1:0]        pos_ff, pos_in;
   logic [bsl_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [bsl_pkg::CNT_W-1:0]        idx_ff, idx_in;
   logic [bsl_pkg::STAT_W-1:0]       stat_ff, stat_in;
   logic [bsl_pkg::FIDX_W-1:0]       found_ff, found_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [bsl_pkg::STAT_W-1:0]       rsp_stat_ff, rsp_stat_in;
   logic [bsl_pkg::FIDX_W-1:0]       rsp_found_ff, rsp_found_in;
   logic [bsl_pkg::COUNT_W-1:0]      rsp_count_ff, rsp_count_in;

   logic                             wr_en;
   logic [bsl_pkg::IDX_W-1:0]        wr_addr;
   logic [bsl_pkg::KEY_W-1:0]        wr_data;
   logic [bsl_pkg::IDX_W-1:0]        rd_addr;
   logic [bsl_pkg::KEY_W-1:0]        rd_data;

   logic                             req_fire;
   logic                             rsp_load;
   logic [bsl_pkg::CNT_W-1:0]        idx_up;
   logic [bsl_pkg::CNT_W-1:0]        idx_dn;
   logic [bsl_pkg::CMP_W-1:0]        req_pos_c;
   logic [bsl_pkg::CMP_W-1:0]        cnt_c;
   logic [bsl_pkg::CNT_W:0]          idx_up_w;
   logic                             is_full;

   bsl_ram #(
      .DEPTH (bsl_pkg::CAPACITY),
      .WIDTH (bsl_pkg::KEY_W),
      .AW    (bsl_pkg::IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign idx_up    = idx_ff + 1'b1;
   assign idx_dn    = idx_ff - 1'b1;
   assign idx_up_w  = {1'b0, idx_ff} + 1'b1;
   assign req_pos_c = bsl_pkg::CMP_W'(req_ch.position);
   assign cnt_c     = bsl_pkg::CMP_W'(cnt_ff);
   assign is_full   = (cnt_ff >= bsl_pkg::CNT_W'(bsl_pkg::CAPACITY));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsl_pkg::S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      stat_ff      <= stat_in;
      found_ff     <= found_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_found_ff <= rsp_found_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      stat_in      = stat_ff;
      found_in     = found_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[bsl_pkg::IDX_W-1:0];
      wr_data      = key_ff;
      rd_addr      = idx_ff[bsl_pkg::IDX_W-1:0];
      rsp_load     = 1'b0;
      req_ch.ready = 1'b0;

      unique case (state_ff)
         bsl_pkg::S_IDLE: begin
            req_ch.ready = !reset;
            if (req_ch.valid && !reset) begin
               op_in    = req_ch.op;
               key_in   = req_ch.key;
               pos_in   = req_ch.position;
               stat_in  = bsl_pkg::STAT_OK;
               found_in = bsl_pkg::NONE_INDEX;
               idx_in   = '0;
               state_in = bsl_pkg::S_FINISH;
               unique case (req_ch.op)
                  bsl_pkg::OP_SEARCH, bsl_pkg::OP_DELETE: begin
                     state_in = bsl_pkg::S_SCAN_RD;
                  end
                  bsl_pkg::OP_INSERT: begin
                     if (is_full) begin
                        stat_in = bsl_pkg::STAT_FULL;
                     end else if (req_pos_c > cnt_c) begin
                        stat_in = bsl_pkg::STAT_POS;
                     end else begin
                        // Move entries up from the tail down to the position.
                        idx_in   = cnt_ff;
                        state_in = bsl_pkg::S_SHIFT_RD;
                     end
                  end
                  bsl_pkg::OP_APPEND: begin
                     if (is_full) begin
                        stat_in = bsl_pkg::STAT_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[bsl_pkg::IDX_W-1:0];
                        wr_data = req_ch.key;
                        cnt_in  = cnt_ff + 1'b1;
                     end
                  end
                  bsl_pkg::OP_CLEAR: begin
                     cnt_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         bsl_pkg::S_SCAN_RD: begin
            if (idx_ff >= cnt_ff) begin
               stat_in  = bsl_pkg::STAT_MISS;
               state_in = bsl_pkg::S_FINISH;
            end else begin
               state_in = bsl_pkg::S_SCAN_CMP;
            end
         end

         bsl_pkg::S_SCAN_CMP: begin
            if (rd_data == key_ff) begin
               found_in = bsl_pkg::FIDX_W'(idx_ff);
               if (op_ff == bsl_pkg::OP_DELETE) begin
                  state_in = bsl_pkg::S_SHIFT_RD;
               end else begin
                  state_in = bsl_pkg::S_FINISH;
               end
            end else begin
               idx_in   = idx_up;
               state_in = bsl_pkg::S_SCAN_RD;
            end
         end

         bsl_pkg::S_SHIFT_RD: begin
            if (op_ff == bsl_pkg::OP_DELETE) begin
               // Pull the successor down until the last valid entry moved.
               if (idx_up_w >= {1'b0, cnt_ff}) begin
                  cnt_in   = cnt_ff - 1'b1;
                  state_in = bsl_pkg::S_FINISH;
               end else begin
                  rd_addr  = idx_up[bsl_pkg::IDX_W-1:0];
                  state_in = bsl_pkg::S_SHIFT_WR;
               end
            end else begin
               if (bsl_pkg::CMP_W'(idx_ff) == bsl_pkg::CMP_W'(pos_ff)) begin
                  wr_en    = 1'b1;
                  wr_data  = key_ff;
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = bsl_pkg::S_FINISH;
               end else begin
                  rd_addr  = idx_dn[bsl_pkg::IDX_W-1:0];
                  state_in = bsl_pkg::S_SHIFT_WR;
               end
            end
         end

         bsl_pkg::S_SHIFT_WR: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            state_in = bsl_pkg::S_SHIFT_RD;
            if (op_ff == bsl_pkg::OP_DELETE) begin
               idx_in = idx_up;
            end else begin
               idx_in = idx_dn;
            end
         end

         bsl_pkg::S_FINISH: begin
            // The response register may still hold the previous result.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = bsl_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bsl_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);
      rsp_stat_in  = rsp_stat_ff;
      rsp_found_in = rsp_found_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_load) begin
         rsp_stat_in  = stat_ff;
         rsp_found_in = found_ff;
         rsp_count_in = bsl_pkg::COUNT_W'(cnt_ff);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_stat_ff;
   assign rsp_ch.found_index = rsp_found_ff;
   assign rsp_ch.count       = rsp_count_ff;

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != bsl_pkg::S_IDLE))
      else $error("Sequencer returned to idle right after taking a request.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= bsl_pkg::CNT_W'(bsl_pkg::CAPACITY))
      else $error("Entry count exceeds the list capacity.");

   a_finish_loads_response: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == bsl_pkg::S_IDLE))
      else $error("Finished request did not present a response.");

   a_shift_inside_list: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsl_pkg::S_SHIFT_WR) |-> (idx_ff < bsl_pkg::CNT_W'(bsl_pkg::CAPACITY)))
      else $error("Shift step addresses an entry beyond the capacity.");

endmodule
